@@ rtl/assert_macros.svh @@
// Assertion macros shared by the nearest free slot matcher RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GNM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GNM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GNM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GNM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/gnm_pkg.sv @@
// Types, sizes and codes shared by the nearest free slot matcher
package gnm_pkg;

  localparam int MAX_STATIONS = 16;
  localparam int POS_BITS     = 20;
  localparam int IDX_BITS     = $clog2(MAX_STATIONS);
  localparam int CNT_BITS     = $clog2(MAX_STATIONS + 1);
  localparam int TOTAL_BITS   = 32;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0]   CNT_MAX   = CNT_BITS'(MAX_STATIONS);

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_PLACE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic                act;
    logic                found;
    logic [IDX_BITS-1:0] idx;
    logic [POS_BITS-1:0] gap;
  } search_t;

  typedef struct packed {
    logic                load_en;
    logic [IDX_BITS-1:0] load_idx;
    logic [POS_BITS-1:0] load_pos;
    logic                clear_en;
    logic                mark_en;
    logic [IDX_BITS-1:0] mark_idx;
  } cell_ctrl_t;

endpackage

@@ rtl/gnm_cell.sv @@
// One station cell: holds a position and used flag, compares the passing search word
module gnm_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gnm_pkg::IDX_BITS-1:0]  cell_idx,
  input  logic                          live,
  input  gnm_pkg::cell_ctrl_t           ctrl,
  input  logic [gnm_pkg::POS_BITS-1:0]  query_pos,
  input  gnm_pkg::search_t              word_in,
  output gnm_pkg::search_t              word_out
);

  logic [gnm_pkg::POS_BITS-1:0] pos_r;
  logic                         used_r;
  logic                         used_nxt;
  gnm_pkg::search_t             word_r;
  gnm_pkg::search_t             word_nxt;
  logic [gnm_pkg::POS_BITS-1:0] cur_gap;

  assign cur_gap = (pos_r > query_pos) ? (pos_r - query_pos) : (query_pos - pos_r);

  always_comb begin
    word_nxt = word_in;
    if (word_in.act && live && !used_r) begin
      if (!word_in.found || (cur_gap < word_in.gap)) begin
        word_nxt.found = 1'b1;
        word_nxt.idx   = cell_idx;
        word_nxt.gap   = cur_gap;
      end
    end
    used_nxt = used_r;
    if (ctrl.clear_en) begin
      used_nxt = 1'b0;
    end else if (ctrl.load_en && (ctrl.load_idx == cell_idx)) begin
      used_nxt = 1'b0;
    end else if (ctrl.mark_en && (ctrl.mark_idx == cell_idx)) begin
      used_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= 1'b0;
      word_r.act <= 1'b0;
    end else begin
      used_r     <= used_nxt;
      word_r.act <= word_nxt.act;
    end
    word_r.found <= word_nxt.found;
    word_r.idx   <= word_nxt.idx;
    word_r.gap   <= word_nxt.gap;
    if (ctrl.load_en && (ctrl.load_idx == cell_idx)) begin
      pos_r <= ctrl.load_pos;
    end
  end

  assign word_out = word_r;

endmodule

@@ rtl/greedy_nearest_free_slot_match_core.sv @@
// Top level of the greedy nearest free slot matcher: command control and cell chain
//
//   port group   direction  handshake            payload
//   command      in         start & !busy        in_func, in_position
//   result       out        out_valid, 1 cycle   out_status, out_slot_index, out_distance,
//                                                out_total_distance, out_queries_placed
//
// Load, clear and unused codes give their result one cycle after acceptance.
// A place registers the search word at the chain head; it then walks the cell chain,
// one station per cycle, then the chosen cell is marked.
// busy is high while a place is in flight; start is ignored then.
// Synchronous active-low reset empties the table; stored positions need no reset.
`include "assert_macros.svh"
module greedy_nearest_free_slot_match_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_func,
  input  logic [gnm_pkg::POS_BITS-1:0]    in_position,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [gnm_pkg::IDX_BITS-1:0]    out_slot_index,
  output logic [gnm_pkg::POS_BITS-1:0]    out_distance,
  output logic [gnm_pkg::TOTAL_BITS-1:0]  out_total_distance,
  output logic [gnm_pkg::CNT_BITS-1:0]    out_queries_placed
);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t                          state_r, state_nxt;
  logic [gnm_pkg::CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic [gnm_pkg::CNT_BITS-1:0]    placed_r, placed_nxt;
  logic [gnm_pkg::TOTAL_BITS-1:0]  total_r, total_nxt;
  logic [gnm_pkg::POS_BITS-1:0]    qpos_r;
  gnm_pkg::search_t                head_r, head_nxt;

  logic                            valid_r, valid_nxt;
  logic [1:0]                      status_r, status_nxt;
  logic [gnm_pkg::IDX_BITS-1:0]    slot_r, slot_nxt;
  logic [gnm_pkg::POS_BITS-1:0]    dist_r, dist_nxt;

  logic                            accept;
  logic [gnm_pkg::TOTAL_BITS:0]    sum;
  gnm_pkg::cell_ctrl_t             ctrl;
  gnm_pkg::search_t                words [gnm_pkg::MAX_STATIONS+1];
  gnm_pkg::search_t                tail;
  logic [gnm_pkg::MAX_STATIONS-1:0] live;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign tail   = words[gnm_pkg::MAX_STATIONS];
  assign sum    = {1'b0, total_r} + (gnm_pkg::TOTAL_BITS + 1)'(tail.gap);

  always_comb begin
    ctrl.load_en  = accept && (in_func == gnm_pkg::FUNC_LOAD) && (cnt_r < gnm_pkg::CNT_MAX);
    ctrl.load_idx = cnt_r[gnm_pkg::IDX_BITS-1:0];
    ctrl.load_pos = in_position;
    ctrl.clear_en = accept && (in_func == gnm_pkg::FUNC_CLEAR);
    ctrl.mark_en  = (state_r == S_SCAN) && tail.act && tail.found;
    ctrl.mark_idx = tail.idx;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    placed_nxt   = placed_r;
    total_nxt    = total_r;
    head_nxt     = '0;
    valid_nxt    = 1'b0;
    status_nxt   = gnm_pkg::ST_OK;
    slot_nxt     = '0;
    dist_nxt     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            gnm_pkg::FUNC_LOAD: begin
              valid_nxt = 1'b1;
              if (cnt_r < gnm_pkg::CNT_MAX) begin
                slot_nxt = cnt_r[gnm_pkg::IDX_BITS-1:0];
                cnt_nxt  = cnt_r + 1'b1;
              end else begin
                status_nxt = gnm_pkg::ST_FULL;
              end
            end
            gnm_pkg::FUNC_PLACE: begin
              head_nxt.act = 1'b1;
              state_nxt    = S_SCAN;
            end
            gnm_pkg::FUNC_CLEAR: begin
              valid_nxt  = 1'b1;
              cnt_nxt    = '0;
              placed_nxt = '0;
              total_nxt  = '0;
            end
            default: begin
              valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (tail.act) begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
          if (tail.found) begin
            slot_nxt   = tail.idx;
            dist_nxt   = tail.gap;
            placed_nxt = placed_r + 1'b1;
            total_nxt  = sum[gnm_pkg::TOTAL_BITS] ? gnm_pkg::TOTAL_MAX
                                                  : sum[gnm_pkg::TOTAL_BITS-1:0];
          end else begin
            status_nxt = gnm_pkg::ST_NO_FREE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      placed_r   <= '0;
      total_r    <= '0;
      valid_r    <= 1'b0;
      head_r.act <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      placed_r   <= placed_nxt;
      total_r    <= total_nxt;
      valid_r    <= valid_nxt;
      head_r.act <= head_nxt.act;
    end
    head_r.found <= head_nxt.found;
    head_r.idx   <= head_nxt.idx;
    head_r.gap   <= head_nxt.gap;
    status_r     <= status_nxt;
    slot_r       <= slot_nxt;
    dist_r       <= dist_nxt;
    if (accept && (in_func == gnm_pkg::FUNC_PLACE)) begin
      qpos_r <= in_position;
    end
  end

  assign words[0] = head_r;

  for (genvar i = 0; i < gnm_pkg::MAX_STATIONS; i++) begin : g_cell
    assign live[i] = (cnt_r > gnm_pkg::CNT_BITS'(i));
    gnm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (gnm_pkg::IDX_BITS'(i)),
      .live      (live[i]),
      .ctrl      (ctrl),
      .query_pos (qpos_r),
      .word_in   (words[i]),
      .word_out  (words[i+1])
    );
  end

  assign out_valid          = valid_r;
  assign out_status         = status_r;
  assign out_slot_index     = slot_r;
  assign out_distance       = dist_r;
  assign out_total_distance = total_r;
  assign out_queries_placed = placed_r;

  `GNM_ASSERT_IMP(a_result_idle, clk, rst_n, out_valid, !busy)
  `GNM_ASSERT_NXT(a_place_busy, clk, rst_n, accept && (in_func == gnm_pkg::FUNC_PLACE), busy)
  `GNM_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= gnm_pkg::CNT_MAX)
  `GNM_ASSERT_IMP(a_placed_bound, clk, rst_n, 1'b1, placed_r <= cnt_r)

endmodule

@@ tb/greedy_nearest_free_slot_match_core_test.sv @@
// Self-checking testbench for the greedy nearest free slot matcher core
module greedy_nearest_free_slot_match_core_test;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1000;
  localparam int STALL_LIMIT  = 500;

  typedef struct packed {
    logic [1:0]                     status;
    logic [gnm_pkg::IDX_BITS-1:0]   slot;
    logic [gnm_pkg::POS_BITS-1:0]   gap;
    logic [gnm_pkg::TOTAL_BITS-1:0] total;
    logic [gnm_pkg::CNT_BITS-1:0]   placed;
  } match_word_t;

  typedef struct {
    logic [1:0]                   func;
    logic [gnm_pkg::POS_BITS-1:0] pos;
    int                           reps;
    bit                           known;
    match_word_t                  want;
  } plan_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [1:0]                     in_func;
  logic [gnm_pkg::POS_BITS-1:0]   in_position;
  logic                           out_valid;
  logic [1:0]                     out_status;
  logic [gnm_pkg::IDX_BITS-1:0]   out_slot_index;
  logic [gnm_pkg::POS_BITS-1:0]   out_distance;
  logic [gnm_pkg::TOTAL_BITS-1:0] out_total_distance;
  logic [gnm_pkg::CNT_BITS-1:0]   out_queries_placed;

  // predictor state
  logic [gnm_pkg::POS_BITS-1:0]   station_pos [gnm_pkg::MAX_STATIONS];
  bit [gnm_pkg::MAX_STATIONS-1:0] station_taken;
  int                             station_cnt;
  logic [gnm_pkg::TOTAL_BITS-1:0] run_total;
  int                             placed_cnt;

  match_word_t match_q[$];
  plan_row_t   plan_q[$];
  match_word_t got_want;
  int          err_count;
  int          stall_cycles;
  int          idle_pct;
  bit          drive_on;
  int          n_sent, n_checked, n_loaded, n_full, n_placed, n_no_free, n_cleared;

  greedy_nearest_free_slot_match_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_distance       (out_distance),
    .out_total_distance (out_total_distance),
    .out_queries_placed (out_queries_placed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic match_word_t nearest_free_step(input logic [1:0] func,
                                                    input logic [gnm_pkg::POS_BITS-1:0] pos);
    match_word_t                  w;
    logic [gnm_pkg::POS_BITS-1:0] d;
    logic [gnm_pkg::POS_BITS-1:0] best_d;
    logic [gnm_pkg::TOTAL_BITS:0] sum;
    int                           best;
    int                           j;
    w = '0;
    best = -1;
    best_d = '0;
    case (func)
      gnm_pkg::FUNC_LOAD: begin
        if (station_cnt < gnm_pkg::MAX_STATIONS) begin
          w.slot = gnm_pkg::IDX_BITS'(station_cnt);
          station_pos[station_cnt] = pos;
          station_taken[station_cnt] = 1'b0;
          station_cnt++;
          n_loaded++;
        end else begin
          w.status = gnm_pkg::ST_FULL;
          n_full++;
        end
      end
      gnm_pkg::FUNC_PLACE: begin
        for (j = 0; j < station_cnt; j++) begin
          if (!station_taken[j]) begin
            d = (station_pos[j] > pos) ? station_pos[j] - pos : pos - station_pos[j];
            if (best < 0 || d < best_d) begin
              best = j;
              best_d = d;
            end
          end
        end
        if (best >= 0) begin
          station_taken[best] = 1'b1;
          sum = (gnm_pkg::TOTAL_BITS+1)'(run_total) + (gnm_pkg::TOTAL_BITS+1)'(best_d);
          run_total = sum[gnm_pkg::TOTAL_BITS] ? gnm_pkg::TOTAL_MAX
                                               : sum[gnm_pkg::TOTAL_BITS-1:0];
          placed_cnt++;
          w.slot = gnm_pkg::IDX_BITS'(best);
          w.gap = best_d;
          n_placed++;
        end else begin
          w.status = gnm_pkg::ST_NO_FREE;
          n_no_free++;
        end
      end
      gnm_pkg::FUNC_CLEAR: begin
        station_taken = '0;
        station_cnt = 0;
        run_total = '0;
        placed_cnt = 0;
        n_cleared++;
      end
      default: begin
      end
    endcase
    w.total = run_total;
    w.placed = gnm_pkg::CNT_BITS'(placed_cnt);
    return w;
  endfunction

  function automatic logic [gnm_pkg::POS_BITS-1:0] pick_position();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 4)
      return $urandom_range(0, 1) ? '1 : '0;
    if (mode == 5 || mode == 6)
      return gnm_pkg::POS_BITS'($urandom_range(0, 15));
    if (mode >= 7 && station_cnt > 0)
      return station_pos[$urandom_range(0, station_cnt - 1)]
             + gnm_pkg::POS_BITS'($urandom_range(0, 8)) - gnm_pkg::POS_BITS'(4);
    return gnm_pkg::POS_BITS'($urandom);
  endfunction

  task automatic add_row(input logic [1:0] func, input logic [gnm_pkg::POS_BITS-1:0] pos,
                         input int reps, input bit known, input match_word_t want);
    plan_row_t r;
    r.func = func;
    r.pos = pos;
    r.reps = reps;
    r.known = known;
    r.want = want;
    plan_q.push_back(r);
  endtask

  task automatic send_word(input logic [1:0] func, input logic [gnm_pkg::POS_BITS-1:0] pos,
                           input bit known, input match_word_t want);
    match_word_t calc;
    start <= 1'b1;
    in_func <= func;
    in_position <= pos;
    drive_on = 1'b1;
    do @(posedge clk); while (busy);
    calc = nearest_free_step(func, pos);
    match_q.push_back(known ? want : calc);
    n_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      in_func <= 2'($urandom);
      in_position <= gnm_pkg::POS_BITS'($urandom);
      drive_on = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_checked++;
      if (match_q.size() == 0) begin
        $error("result word with nothing expected");
        err_count++;
      end else begin
        got_want = match_q.pop_front();
        if (out_status !== got_want.status) begin
          $error("out_status expected %0d got %0d", got_want.status, out_status);
          err_count++;
        end
        if (out_slot_index !== got_want.slot) begin
          $error("out_slot_index expected %0d got %0d", got_want.slot, out_slot_index);
          err_count++;
        end
        if (out_distance !== got_want.gap) begin
          $error("out_distance expected %0h got %0h", got_want.gap, out_distance);
          err_count++;
        end
        if (out_total_distance !== got_want.total) begin
          $error("out_total_distance expected %0h got %0h", got_want.total,
                 out_total_distance);
          err_count++;
        end
        if (out_queries_placed !== got_want.placed) begin
          $error("out_queries_placed expected %0d got %0d", got_want.placed,
                 out_queries_placed);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("greedy_nearest_free_slot_match_core verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int n_ld, n_pl, rnd_base, k;
    bit mixed;
    plan_row_t r;
    station_taken = '0;
    station_cnt = 0;
    run_total = '0;
    placed_cnt = 0;
    for (k = 0; k < gnm_pkg::MAX_STATIONS; k++) station_pos[k] = '0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_func <= gnm_pkg::FUNC_LOAD;
    in_position <= '0;
    drive_on = 1'b0;
    idle_pct = 23;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    add_row(gnm_pkg::FUNC_PLACE, 20'd0, 1, 1,
            {gnm_pkg::ST_NO_FREE, 4'd0, 20'd0, 32'd0, 5'd0});
    add_row(FUNC_UNUSED, 20'hFFFFF, 1, 1, {gnm_pkg::ST_OK, 4'd0, 20'd0, 32'd0, 5'd0});
    add_row(gnm_pkg::FUNC_LOAD, 20'd0, 1, 1, {gnm_pkg::ST_OK, 4'd0, 20'd0, 32'd0, 5'd0});
    add_row(gnm_pkg::FUNC_LOAD, 20'hFFFFF, 1, 1,
            {gnm_pkg::ST_OK, 4'd1, 20'd0, 32'd0, 5'd0});
    add_row(gnm_pkg::FUNC_PLACE, 20'hFFFFF, 1, 1,
            {gnm_pkg::ST_OK, 4'd1, 20'd0, 32'd0, 5'd1});
    add_row(gnm_pkg::FUNC_PLACE, 20'd0, 1, 1, {gnm_pkg::ST_OK, 4'd0, 20'd0, 32'd0, 5'd2});
    add_row(gnm_pkg::FUNC_PLACE, 20'd5, 1, 1,
            {gnm_pkg::ST_NO_FREE, 4'd0, 20'd0, 32'd0, 5'd2});
    add_row(gnm_pkg::FUNC_LOAD, 20'd100, 2, 0, '0);
    add_row(gnm_pkg::FUNC_PLACE, 20'd100, 1, 0, '0);
    add_row(gnm_pkg::FUNC_LOAD, 20'h7FFFF, 1, 0, '0);
    add_row(gnm_pkg::FUNC_LOAD, 20'h80001, 1, 0, '0);
    add_row(gnm_pkg::FUNC_PLACE, 20'h80000, 1, 0, '0);
    add_row(gnm_pkg::FUNC_PLACE, 20'hFFFFF, 1, 0, '0);
    add_row(gnm_pkg::FUNC_CLEAR, 20'hFFFFF, 1, 1,
            {gnm_pkg::ST_OK, 4'd0, 20'd0, 32'd0, 5'd0});
    add_row(gnm_pkg::FUNC_LOAD, 20'hFFFFF, 16, 0, '0);
    add_row(gnm_pkg::FUNC_LOAD, 20'd0, 1, 1, {gnm_pkg::ST_FULL, 4'd0, 20'd0, 32'd0, 5'd0});
    add_row(gnm_pkg::FUNC_PLACE, 20'd0, 1, 0, '0);
    add_row(gnm_pkg::FUNC_CLEAR, 20'd0, 1, 1, {gnm_pkg::ST_OK, 4'd0, 20'd0, 32'd0, 5'd0});

    foreach (plan_q[i]) begin
      r = plan_q[i];
      repeat (r.reps) send_word(r.func, r.pos, r.known, r.want);
    end

    rnd_base = n_sent;
    while (n_sent - rnd_base < RANDOM_WORDS) begin
      case ((n_sent - rnd_base) * 3 / RANDOM_WORDS)
        0: idle_pct = 23;
        1: idle_pct = 55;
        default: idle_pct = 0;
      endcase
      if ($urandom_range(0, 4) != 0)
        send_word(gnm_pkg::FUNC_CLEAR, pick_position(), 1'b0, '0);
      if ($urandom_range(0, 3) == 0) begin
        n_ld = $urandom_range(16, 17);
        n_pl = $urandom_range(16, 18);
      end else begin
        n_ld = $urandom_range(0, 16);
        n_pl = $urandom_range(0, n_ld + 2);
      end
      mixed = ($urandom_range(0, 3) == 0);
      while (n_ld + n_pl > 0) begin
        if ($urandom_range(0, 99) < 3) begin
          send_word($urandom_range(0, 1) ? FUNC_UNUSED : gnm_pkg::FUNC_CLEAR,
                    pick_position(), 1'b0, '0);
        end else if (n_ld > 0 && (!mixed || n_pl == 0 || $urandom_range(0, 1) == 1)) begin
          send_word(gnm_pkg::FUNC_LOAD, pick_position(), 1'b0, '0);
          n_ld--;
        end else begin
          send_word(gnm_pkg::FUNC_PLACE, pick_position(), 1'b0, '0);
          n_pl--;
        end
      end
    end

    if (drive_on) start <= 1'b0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (gnm_pkg::MAX_STATIONS + 4) @(posedge clk);

    $display("%0d words sent, %0d results checked", n_sent, n_checked);
    $display("loads %0d, full %0d, places %0d, no free slot %0d, clears %0d",
             n_loaded, n_full, n_placed, n_no_free, n_cleared);
    if (err_count == 0) begin
      $display("greedy_nearest_free_slot_match_core verification clean");
    end else begin
      $display("greedy_nearest_free_slot_match_core verification failed");
    end
    $finish;
  end

endmodule
